// ===== design/etpf_pkg.sv =====
// ----------------------------------------------------------------------------
// etpf_pkg: shared types and constants of the edge trigger period finder
// Field widths, configuration register indexes and the result record.
// ----------------------------------------------------------------------------
package etpf_pkg;

    localparam int SAMPLE_W = 8;
    localparam int INDEX_W  = 12;   // running sample index, saturating
    localparam int POS_W    = 11;   // reported crossing index and period
    localparam int COUNT_W  = 2;

    localparam logic [INDEX_W-1:0] INDEX_MAX = {INDEX_W{1'b1}};

    // Configuration register indexes
    localparam logic CFG_TRIGGER_LEVEL = 1'b0;
    localparam logic CFG_EDGE_FALLING  = 1'b1;

    // Crossing counts
    localparam logic [COUNT_W-1:0] FOUND_NONE = 2'd0;
    localparam logic [COUNT_W-1:0] FOUND_ONE  = 2'd1;
    localparam logic [COUNT_W-1:0] FOUND_TWO  = 2'd2;

    localparam logic [SAMPLE_W-1:0] LEVEL_RESET = 8'd128;

    typedef struct packed {
        logic [COUNT_W-1:0] found_count;
        logic [POS_W-1:0]   first_index;
        logic [POS_W-1:0]   period_samples;
    } t_result;

endpackage

// ===== design/etpf_edge_det.sv =====
// ----------------------------------------------------------------------------
// etpf_edge_det: trigger level crossing detector
// Compares the previous and current samples against the trigger level.
// ----------------------------------------------------------------------------
module etpf_edge_det
    import etpf_pkg::*;
(
    input  logic [SAMPLE_W-1:0] i_prev,
    input  logic [SAMPLE_W-1:0] i_cur,
    input  logic [SAMPLE_W-1:0] i_level,
    input  logic                i_falling,
    output logic                o_crossing
);

    logic w_rise;
    logic w_fall;

    // Rising: from below the level to at or above it; falling is the mirror.
    assign w_rise = (i_prev < i_level) && (i_cur >= i_level);
    assign w_fall = (i_prev > i_level) && (i_cur <= i_level);

    assign o_crossing = i_falling ? w_fall : w_rise;

endmodule

// ===== design/etpf_tracker.sv =====
// ----------------------------------------------------------------------------
// etpf_tracker: capture state and crossing bookkeeping
// Holds the sample index, previous sample and first two crossings of a capture.
// ----------------------------------------------------------------------------
module etpf_tracker
    import etpf_pkg::*;
#(
    parameter int CAPTURE_LENGTH = 2048
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_advance,
    input  logic [SAMPLE_W-1:0] i_sample,
    input  logic                i_last,
    input  logic [SAMPLE_W-1:0] i_level,
    input  logic                i_falling,
    output t_result             o_result
);

    localparam int WINDOW_END = CAPTURE_LENGTH / 2;
    localparam logic [INDEX_W-1:0] WINDOW_LIMIT = INDEX_W'(WINDOW_END);

    logic [SAMPLE_W-1:0] r_prev;
    logic [INDEX_W-1:0]  r_index;
    logic [COUNT_W-1:0]  r_found;
    logic [POS_W-1:0]    r_first;
    logic [POS_W-1:0]    r_gap;

    logic [COUNT_W-1:0]  n_found;
    logic [POS_W-1:0]    n_first;
    logic [POS_W-1:0]    n_gap;
    logic [INDEX_W-1:0]  n_index;

    logic w_crossing;
    logic w_in_window;
    logic w_hit;

    etpf_edge_det u_edge_det (
        .i_prev     (r_prev),
        .i_cur      (i_sample),
        .i_level    (i_level),
        .i_falling  (i_falling),
        .o_crossing (w_crossing)
    );

    // The first sample of a capture has no predecessor and is never tested.
    assign w_in_window = (r_index != '0) && (r_index < WINDOW_LIMIT);
    assign w_hit       = w_in_window && (r_found != FOUND_TWO) && w_crossing;

    always_comb begin
        n_found = r_found;
        n_first = r_first;
        n_gap   = r_gap;
        if (w_hit) begin
            if (r_found == FOUND_NONE) begin
                n_first = r_index[POS_W-1:0];
                n_found = FOUND_ONE;
            end else begin
                n_gap   = r_index[POS_W-1:0] - r_first;
                n_found = FOUND_TWO;
            end
        end
        n_index = (r_index == INDEX_MAX) ? r_index : r_index + 1'b1;
    end

    always_comb begin
        o_result.found_count    = n_found;
        o_result.first_index    = (n_found != FOUND_NONE) ? n_first : '0;
        o_result.period_samples = (n_found == FOUND_TWO) ? n_gap : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev  <= '0;
            r_index <= '0;
            r_found <= FOUND_NONE;
            r_first <= '0;
            r_gap   <= '0;
        end else if (i_advance) begin
            r_prev <= i_sample;
            if (i_last) begin
                r_index <= '0;
                r_found <= FOUND_NONE;
                r_first <= '0;
                r_gap   <= '0;
            end else begin
                r_index <= n_index;
                r_found <= n_found;
                r_first <= n_first;
                r_gap   <= n_gap;
            end
        end
    end

endmodule

// ===== design/edge_trigger_period_finder_core.sv =====
// ----------------------------------------------------------------------------
// edge_trigger_period_finder_core: oscilloscope style edge trigger search
// Finds the first two level crossings in the first half of each capture.
// ----------------------------------------------------------------------------
// Result path: the last sample of a capture is held in the input register and
// the result register captures the result when free; o_valid then rises.
// Throughput: one sample per clock while the result register is not held by
// i_stall; the per-sample compare and state update sit between the input
// register and the result register.
// Reset (synchronous, active low) clears all capture state, sets the trigger
// level to 128 and selects rising edges.
// ----------------------------------------------------------------------------
module edge_trigger_period_finder_core
    import etpf_pkg::*;
#(
    parameter int CAPTURE_LENGTH = 2048
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // Configuration write port
    input  logic                i_cfg_we,
    input  logic                i_cfg_index,
    input  logic [SAMPLE_W-1:0] i_cfg_data,
    // Sample channel
    input  logic                i_valid,
    output logic                o_stall,
    input  logic [SAMPLE_W-1:0] i_sample,
    input  logic                i_last_sample,
    // Result channel
    output logic                o_valid,
    input  logic                i_stall,
    output logic [COUNT_W-1:0]  o_found_count,
    output logic [POS_W-1:0]    o_first_index,
    output logic [POS_W-1:0]    o_period_samples
);

    // Configuration registers. The user must see that they are only written while
    // no transaction is in flight, so the tracker may read them directly; the block does not enforce this.
    logic [SAMPLE_W-1:0] r_trigger_level;
    logic                r_edge_falling;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_trigger_level <= LEVEL_RESET;
            r_edge_falling  <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_TRIGGER_LEVEL: r_trigger_level <= i_cfg_data;
                CFG_EDGE_FALLING:  r_edge_falling  <= i_cfg_data[0];
                default:           r_trigger_level <= r_trigger_level;
            endcase
        end
    end

    // Handshake. The result register frees when empty or when its transaction
    // is taken; the input register advances into the tracker whenever the
    // result register can absorb a possible result, and refills in the same
    // cycle, so samples stream at one per clock.
    logic    r_in_valid;
    logic [SAMPLE_W-1:0] r_in_sample;
    logic    r_in_last;
    logic    r_out_valid;
    t_result r_out;
    t_result w_result;
    logic    w_out_free;
    logic    w_advance;
    logic    w_in_free;

    assign w_out_free = !r_out_valid || !i_stall;
    assign w_advance  = r_in_valid && w_out_free;
    assign w_in_free  = !r_in_valid || w_advance;
    assign o_stall    = !w_in_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_free) begin
            r_in_valid <= i_valid;
        end
    end

    // Payload of the input register needs no reset.
    always_ff @(posedge i_clk) begin
        if (w_in_free) begin
            r_in_sample <= i_sample;
            r_in_last   <= i_last_sample;
        end
    end

    etpf_tracker #(
        .CAPTURE_LENGTH (CAPTURE_LENGTH)
    ) u_tracker (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (w_advance),
        .i_sample  (r_in_sample),
        .i_last    (r_in_last),
        .i_level   (r_trigger_level),
        .i_falling (r_edge_falling),
        .o_result  (w_result)
    );

    // Only the last sample of a capture produces a result transaction.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_free) begin
            r_out_valid <= w_advance && r_in_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_free) begin
            r_out <= w_result;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_found_count    = r_out.found_count;
    assign o_first_index    = r_out.first_index;
    assign o_period_samples = r_out.period_samples;

    // A held result must block the tracker from moving on.
    a_no_advance_when_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_stall) |-> !w_advance)
        else $error("tracker advanced while result register was held");

    // Upstream is only stalled when a sample is waiting in the input register.
    a_stall_needs_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> r_in_valid)
        else $error("stall raised with empty input register");

    // The crossing count never exceeds two.
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_found_count != 2'd3))
        else $error("found count out of range");

    // A period is only reported once two crossings were seen.
    a_period_needs_two: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_found_count != FOUND_TWO)) |-> (o_period_samples == '0))
        else $error("period reported with fewer than two crossings");

    // A result transaction follows an advancing last sample.
    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(w_advance && r_in_last))
        else $error("result appeared without a last sample");

endmodule
